[src/sscr_pkg.sv]
// Shared types, constants and the built-in font for the seven-segment renderer.
// No dependencies.
package sscr_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int FONT_DEPTH  = 96;
  localparam int FONT_AW     = 7;

  localparam logic [1:0] CFG_LOWERCASE = 2'd0;
  localparam logic [1:0] CFG_DOT_MODE  = 2'd1;
  localparam logic [1:0] CFG_GLOBAL_BR = 2'd2;
  localparam logic [1:0] CFG_XOR_MASK  = 2'd3;

  localparam logic [6:0] ASCII_BASE = 7'd32;
  localparam logic [6:0] ASCII_UA   = 7'h41;
  localparam logic [6:0] ASCII_UZ   = 7'h5A;
  localparam logic [6:0] ASCII_LA   = 7'h61;
  localparam logic [6:0] ASCII_LZ   = 7'h7A;

  localparam logic [7:0] SEG_MASK = 8'h7F;
  localparam logic [7:0] DOT_MASK = 8'h80;

  // p / 15 for p <= 225 as (p * 137) >> 11
  localparam logic [15:0] DIV15_MUL   = 16'd137;
  localparam int          DIV15_SHIFT = 11;

  localparam logic [3:0] DIGIT_REG0 = 4'd0;
  localparam logic [3:0] DIGIT_REG1 = 4'd2;
  localparam logic [3:0] DIGIT_REG2 = 4'd6;
  localparam logic [3:0] DIGIT_REG3 = 4'd8;

  localparam int ATTR_RAW    = 0;
  localparam int ATTR_HIDDEN = 1;
  localparam int ATTR_BLINK  = 2;
  localparam int ATTR_INVERT = 3;
  localparam int ATTR_XMASK  = 4;
  localparam int ATTR_DOT    = 5;

  localparam logic [7:0] FONT_ROM [FONT_DEPTH] = '{
    8'h00, 8'h0A, 8'h22, 8'h36, 8'h2D, 8'h24, 8'h78, 8'h42,
    8'h39, 8'h0F, 8'h63, 8'h46, 8'h0C, 8'h40, 8'h08, 8'h52,
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27,
    8'h7F, 8'h6F, 8'h09, 8'h0D, 8'h46, 8'h48, 8'h70, 8'h53,
    8'h7B, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D,
    8'h76, 8'h06, 8'h1E, 8'h75, 8'h38, 8'h2B, 8'h37, 8'h3F,
    8'h73, 8'h67, 8'h31, 8'h6D, 8'h07, 8'h3E, 8'h6A, 8'h7E,
    8'h49, 8'h6E, 8'h5B, 8'h39, 8'h64, 8'h0F, 8'h23, 8'h08,
    8'h60, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
    8'h74, 8'h05, 8'h0E, 8'h75, 8'h06, 8'h55, 8'h54, 8'h5C,
    8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h1D, 8'h7E,
    8'h48, 8'h6E, 8'h5B, 8'h46, 8'h30, 8'h70, 8'h01, 8'h00
  };

  typedef enum logic [1:0] {
    OP_PATTERN,
    OP_GLYPH,
    OP_WRITE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [FONT_AW-1:0] addr;
    logic [7:0]       pattern;
    logic             dot_flip;
    logic             invert;
    logic             xmask;
    logic             dot;
    logic [3:0]       digit_register;
    logic [7:0]       bright_product;
    logic [1:0]       blink;
    logic [1:0]       colon;
  } work_t;

  typedef struct packed {
    logic [7:0] segment_data;
    logic [3:0] digit_register;
    logic [3:0] module_brightness;
    logic [1:0] module_blink;
    logic [1:0] colon_bits;
  } result_t;

  function automatic logic [7:0] font_rom(input logic [FONT_AW-1:0] idx);
    logic [7:0] val;
    val = 8'h00;
    if (idx < FONT_AW'(FONT_DEPTH)) begin
      val = FONT_ROM[idx];
    end
    return val;
  endfunction

endpackage

[src/sscr_queue.sv]
// Small register queue used between stages and at the result side.
// Depends on nothing; widths come in as parameters.
module sscr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic             do_wr, do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (!do_wr && do_rd) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[src/sscr_front.sv]
// Front end: config registers, item accept and classification into work entries.
// Depends on sscr_pkg and sscr_queue.
module sscr_front #(
  parameter int DEPTH = sscr_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               push,
  output logic               full,
  input  logic               action,
  input  logic [7:0]         char_code,
  input  logic [5:0]         char_attr,
  input  logic [1:0]         digit_position,
  input  logic               blink_phase,
  input  logic [7:0]         module_attr,
  input  logic [7:0]         font_data,
  output logic [7:0]         xor_mask,
  input  logic               work_pop,
  output sscr_pkg::work_t    work_item,
  output logic               work_empty
);

  localparam int WW = $bits(sscr_pkg::work_t);
  localparam int CW = $clog2(DEPTH + 1);

  logic       lowercase_mode;
  logic [7:0] dot_mode;
  logic [3:0] global_brightness;

  sscr_pkg::work_t  item;
  logic             enq;
  logic [6:0]       c_raw, c_fold;
  logic             upper, lower, high, blank, dflip;
  logic [WW-1:0]    q_out;
  logic [CW-1:0]    q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lowercase_mode    <= 1'b1;
      dot_mode          <= 8'h00;
      global_brightness <= 4'hF;
      xor_mask          <= 8'h00;
    end else if (cfg_valid) begin
      if (cfg_index == {6'd0, sscr_pkg::CFG_LOWERCASE}) lowercase_mode    <= cfg_data[0];
      if (cfg_index == {6'd0, sscr_pkg::CFG_DOT_MODE})  dot_mode          <= cfg_data;
      if (cfg_index == {6'd0, sscr_pkg::CFG_GLOBAL_BR}) global_brightness <= cfg_data[3:0];
      if (cfg_index == {6'd0, sscr_pkg::CFG_XOR_MASK})  xor_mask          <= cfg_data;
    end
  end

  always_comb begin
    c_raw  = char_code[6:0];
    high   = char_code[7];
    upper  = (c_raw >= sscr_pkg::ASCII_UA) && (c_raw <= sscr_pkg::ASCII_UZ);
    lower  = (c_raw >= sscr_pkg::ASCII_LA) && (c_raw <= sscr_pkg::ASCII_LZ);
    c_fold = (lower && !lowercase_mode) ? c_raw - sscr_pkg::ASCII_BASE : c_raw;
    blank  = char_attr[sscr_pkg::ATTR_HIDDEN] ||
             (char_attr[sscr_pkg::ATTR_BLINK] && blink_phase);
    dflip  = (dot_mode[7] && high) ^ (dot_mode[1] && upper) ^ (dot_mode[0] && lower);

    item.op             = sscr_pkg::OP_PATTERN;
    item.addr           = c_fold - sscr_pkg::ASCII_BASE;
    item.pattern        = 8'h00;
    item.dot_flip       = dflip;
    item.invert         = char_attr[sscr_pkg::ATTR_INVERT];
    item.xmask          = char_attr[sscr_pkg::ATTR_XMASK];
    item.dot            = char_attr[sscr_pkg::ATTR_DOT];
    item.bright_product = {4'd0, module_attr[7:4]} * {4'd0, global_brightness};
    item.blink          = module_attr[3:2];
    item.colon          = module_attr[1:0];
    unique case (digit_position)
      2'd0: item.digit_register = sscr_pkg::DIGIT_REG0;
      2'd1: item.digit_register = sscr_pkg::DIGIT_REG1;
      2'd2: item.digit_register = sscr_pkg::DIGIT_REG2;
      2'd3: item.digit_register = sscr_pkg::DIGIT_REG3;
    endcase
    enq = push && !full;

    if (action) begin
      item.op      = sscr_pkg::OP_WRITE;
      item.addr    = c_raw - sscr_pkg::ASCII_BASE;
      item.pattern = font_data;
      enq          = enq && (c_raw >= sscr_pkg::ASCII_BASE);
    end else if (blank) begin
      item.pattern = 8'h00;
    end else if (char_attr[sscr_pkg::ATTR_RAW]) begin
      item.pattern = char_code;
    end else if (c_fold < sscr_pkg::ASCII_BASE) begin
      item.pattern = {dflip, 7'd0};
    end else begin
      item.op = sscr_pkg::OP_GLYPH;
    end
  end

  sscr_queue #(.WIDTH(WW), .DEPTH(DEPTH)) u_work_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (enq),
    .wr_data (item),
    .rd_en   (work_pop),
    .rd_data (q_out),
    .full    (full),
    .empty   (work_empty),
    .count   (q_count)
  );

  assign work_item = sscr_pkg::work_t'(q_out);

endmodule

[src/sscr_back.sv]
// Back end: font memory with per-entry valid bits, segment assembly, result queue.
// Depends on sscr_pkg and sscr_queue.
module sscr_back #(
  parameter int DEPTH = sscr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       xor_mask,
  input  sscr_pkg::work_t  work_item,
  input  logic             work_empty,
  output logic             work_pop,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       segment_data,
  output logic [3:0]       digit_register,
  output logic [3:0]       module_brightness,
  output logic [1:0]       module_blink,
  output logic [1:0]       colon_bits
);

  localparam int RW = $bits(sscr_pkg::result_t);
  localparam int CW = $clog2(DEPTH + 1);

  logic [7:0]      font_mem [sscr_pkg::FONT_DEPTH];
  logic [sscr_pkg::FONT_DEPTH-1:0] font_valid;

  logic            s1_valid;
  sscr_pkg::work_t s1_item;
  logic [7:0]      s1_ram, s1_rom;
  logic            s1_written;

  logic [CW-1:0]   out_count;
  logic            out_full;
  logic            font_we;
  logic [7:0]      seg;
  logic [15:0]     bright_scaled;
  sscr_pkg::result_t res, res_out;
  logic [RW-1:0]   q_out;

  assign work_pop = !work_empty &&
                    (({1'b0, out_count} + {{CW{1'b0}}, s1_valid}) < (CW + 1)'(DEPTH));
  assign font_we  = work_pop && (work_item.op == sscr_pkg::OP_WRITE);

  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[work_item.addr] <= work_item.pattern;
    end
    s1_ram <= font_mem[work_item.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      font_valid <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (font_we) begin
        font_valid[work_item.addr] <= 1'b1;
      end
      s1_valid <= work_pop && (work_item.op != sscr_pkg::OP_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    s1_item    <= work_item;
    s1_rom     <= sscr_pkg::font_rom(work_item.addr);
    s1_written <= font_valid[work_item.addr];
  end

  always_comb begin
    unique case (s1_item.op)
      sscr_pkg::OP_GLYPH:
        seg = (s1_written ? s1_ram : s1_rom) ^ {s1_item.dot_flip, 7'd0};
      sscr_pkg::OP_PATTERN: seg = s1_item.pattern;
      default:              seg = 8'h00;
    endcase
    if (s1_item.invert) seg = seg ^ sscr_pkg::SEG_MASK;
    if (s1_item.xmask)  seg = seg ^ xor_mask;
    if (s1_item.dot)    seg = seg ^ sscr_pkg::DOT_MASK;

    bright_scaled = {8'd0, s1_item.bright_product} * sscr_pkg::DIV15_MUL;

    res.segment_data      = seg;
    res.digit_register    = s1_item.digit_register;
    res.module_brightness = bright_scaled[sscr_pkg::DIV15_SHIFT +: 4];
    res.module_blink      = s1_item.blink;
    res.colon_bits        = s1_item.colon;
  end

  sscr_queue #(.WIDTH(RW), .DEPTH(DEPTH)) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s1_valid),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (q_out),
    .full    (out_full),
    .empty   (empty),
    .count   (out_count)
  );

  always_comb begin
    res_out           = sscr_pkg::result_t'(q_out);
    segment_data      = res_out.segment_data;
    digit_register    = res_out.digit_register;
    module_brightness = res_out.module_brightness;
    module_blink      = res_out.module_blink;
    colon_bits        = res_out.colon_bits;
  end

endmodule

[src/seven_segment_char_renderer.sv]
// Top level of the seven-segment character renderer: front end, work queue, back end.
// Depends on sscr_pkg, sscr_front, sscr_back.
//
//  channel   handshake            payload
//  input     push / full          action char_code char_attr digit_position
//                                 blink_phase module_attr font_data
//  result    pop / empty          segment_data digit_register module_brightness
//                                 module_blink colon_bits
//  config    cfg_valid/cfg_ready  cfg_index cfg_data
//
// One item per cycle sustained while full stays low and results are popped; a render item
// passes the work queue, the font memory read stage and the result queue on its way to
// the result ports, where it can be popped.
// Reset clears the font valid bits, so every entry reads as the built-in font
// until written; no clearing pass is needed.
// Each queue holds QUEUE_DEPTH items, so either side may stall independently.
module seven_segment_char_renderer #(
  parameter int QUEUE_DEPTH = sscr_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic       action,
  input  logic [7:0] char_code,
  input  logic [5:0] char_attr,
  input  logic [1:0] digit_position,
  input  logic       blink_phase,
  input  logic [7:0] module_attr,
  input  logic [7:0] font_data,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] segment_data,
  output logic [3:0] digit_register,
  output logic [3:0] module_brightness,
  output logic [1:0] module_blink,
  output logic [1:0] colon_bits
);

  sscr_pkg::work_t work_item;
  logic            work_empty;
  logic            work_pop;
  logic [7:0]      xor_mask;

  sscr_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .action         (action),
    .char_code      (char_code),
    .char_attr      (char_attr),
    .digit_position (digit_position),
    .blink_phase    (blink_phase),
    .module_attr    (module_attr),
    .font_data      (font_data),
    .xor_mask       (xor_mask),
    .work_pop       (work_pop),
    .work_item      (work_item),
    .work_empty     (work_empty)
  );

  sscr_back #(.DEPTH(QUEUE_DEPTH)) u_back (
    .clk               (clk),
    .rst               (rst),
    .xor_mask          (xor_mask),
    .work_item         (work_item),
    .work_empty        (work_empty),
    .work_pop          (work_pop),
    .pop               (pop),
    .empty             (empty),
    .segment_data      (segment_data),
    .digit_register    (digit_register),
    .module_brightness (module_brightness),
    .module_blink      (module_blink),
    .colon_bits        (colon_bits)
  );

endmodule

[src/sscr_checker.sv]
// Port-level checks for the seven-segment renderer, bound to the top level.
// Depends on seven_segment_char_renderer.
module sscr_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       pop,
  input logic       empty,
  input logic [7:0] segment_data,
  input logic [3:0] digit_register,
  input logic [3:0] module_brightness,
  input logic [1:0] module_blink,
  input logic [1:0] colon_bits
);

  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_digit_reg: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (digit_register == 4'd0 || digit_register == 4'd2 ||
                digit_register == 4'd6 || digit_register == 4'd8))
    else $error("illegal digit register");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(segment_data) && $stable(digit_register) &&
                          $stable(module_brightness) && $stable(colon_bits)))
    else $error("waiting result changed");

endmodule

bind seven_segment_char_renderer sscr_checker u_sscr_checker (
  .clk               (clk),
  .rst               (rst),
  .push              (push),
  .full              (full),
  .pop               (pop),
  .empty             (empty),
  .segment_data      (segment_data),
  .digit_register    (digit_register),
  .module_brightness (module_brightness),
  .module_blink      (module_blink),
  .colon_bits        (colon_bits)
);

[test/seven_segment_char_renderer_tb.sv]
// Self-checking testbench for seven_segment_char_renderer: directed and random cells and
// font writes, register changes between phases, and random idling on both queue sides.
// Depends on sscr_pkg and the seven_segment_char_renderer RTL.
`timescale 1ns / 1ps

module seven_segment_char_renderer_tb;

  localparam logic ACT_RENDER = 1'b0;
  localparam logic ACT_WRITE  = 1'b1;
  localparam int   CYCLE_LIMIT = 300000;
  localparam int   SETTLE_CYCLES = 8;

  localparam logic [7:0] GLYPH_INIT [96] = '{
    8'h00, 8'h0A, 8'h22, 8'h36, 8'h2D, 8'h24, 8'h78, 8'h42,
    8'h39, 8'h0F, 8'h63, 8'h46, 8'h0C, 8'h40, 8'h08, 8'h52,
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27,
    8'h7F, 8'h6F, 8'h09, 8'h0D, 8'h46, 8'h48, 8'h70, 8'h53,
    8'h7B, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D,
    8'h76, 8'h06, 8'h1E, 8'h75, 8'h38, 8'h2B, 8'h37, 8'h3F,
    8'h73, 8'h67, 8'h31, 8'h6D, 8'h07, 8'h3E, 8'h6A, 8'h7E,
    8'h49, 8'h6E, 8'h5B, 8'h39, 8'h64, 8'h0F, 8'h23, 8'h08,
    8'h60, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
    8'h74, 8'h05, 8'h0E, 8'h75, 8'h06, 8'h55, 8'h54, 8'h5C,
    8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h1D, 8'h7E,
    8'h48, 8'h6E, 8'h5B, 8'h46, 8'h30, 8'h70, 8'h01, 8'h00
  };

  typedef struct packed {
    logic       action;
    logic [7:0] code;
    logic [5:0] attr;
    logic [1:0] pos;
    logic       phase;
    logic [7:0] mattr;
    logic [7:0] fdata;
  } cell_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = 8'h00;
  logic [7:0] cfg_data = 8'h00;
  logic       push = 1'b0;
  logic       full;
  logic       action = 1'b0;
  logic [7:0] char_code = 8'h00;
  logic [5:0] char_attr = 6'h00;
  logic [1:0] digit_position = 2'd0;
  logic       blink_phase = 1'b0;
  logic [7:0] module_attr = 8'h00;
  logic [7:0] font_data = 8'h00;
  logic       pop = 1'b0;
  logic       empty;
  logic [7:0] segment_data;
  logic [3:0] digit_register;
  logic [3:0] module_brightness;
  logic [1:0] module_blink;
  logic [1:0] colon_bits;

  // predictor state
  logic [7:0] glyph_mem [96];
  logic       lowercase_on;
  logic [7:0] dot_sel;
  logic [3:0] bright_scale;
  logic [7:0] xor_pattern;

  sscr_pkg::result_t due_renders [$];
  int      mismatch_count = 0;
  bit      send_idle_on = 1'b0;
  bit      recv_idle_on = 1'b0;
  int      recv_hold = 0;

  seven_segment_char_renderer uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .action(action), .char_code(char_code),
    .char_attr(char_attr), .digit_position(digit_position), .blink_phase(blink_phase),
    .module_attr(module_attr), .font_data(font_data),
    .pop(pop), .empty(empty), .segment_data(segment_data), .digit_register(digit_register),
    .module_brightness(module_brightness), .module_blink(module_blink),
    .colon_bits(colon_bits)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [7:0] cell_segments(input cell_item_t it);
    logic [7:0] seg;
    logic [6:0] ch;
    logic       is_upper;
    logic       is_lower;
    ch = it.code[6:0];
    is_upper = (ch >= 7'h41) && (ch <= 7'h5A);
    is_lower = (ch >= 7'h61) && (ch <= 7'h7A);
    if (it.attr[sscr_pkg::ATTR_HIDDEN] || (it.attr[sscr_pkg::ATTR_BLINK] && it.phase)) begin
      seg = 8'h00;
    end else if (it.attr[sscr_pkg::ATTR_RAW]) begin
      seg = it.code;
    end else begin
      if (is_lower && !lowercase_on) ch = ch - 7'd32;
      seg = (ch < 7'd32) ? 8'h00 : glyph_mem[ch - 7'd32];
      if (dot_sel[7] && it.code[7]) seg ^= 8'h80;
      if (dot_sel[1] && is_upper) seg ^= 8'h80;
      if (dot_sel[0] && is_lower) seg ^= 8'h80;
    end
    if (it.attr[sscr_pkg::ATTR_INVERT]) seg ^= 8'h7F;
    if (it.attr[sscr_pkg::ATTR_XMASK]) seg ^= xor_pattern;
    if (it.attr[sscr_pkg::ATTR_DOT]) seg ^= 8'h80;
    return seg;
  endfunction

  function automatic sscr_pkg::result_t render_result(input cell_item_t it);
    sscr_pkg::result_t r;
    logic [3:0] slot;
    int         level;
    slot = (it.pos >= 2'd2) ? 4'(it.pos) + 4'd1 : 4'(it.pos);
    level = int'(it.mattr[7:4]) * int'(bright_scale) / 15;
    r.segment_data = cell_segments(it);
    r.digit_register = slot << 1;
    r.module_brightness = 4'(level);
    r.module_blink = it.mattr[3:2];
    r.colon_bits = it.mattr[1:0];
    return r;
  endfunction

  function automatic cell_item_t render_cell(input logic [7:0] code, input logic [5:0] attr,
                                             input logic [1:0] pos, input logic phase,
                                             input logic [7:0] mattr);
    cell_item_t it;
    it = '{ACT_RENDER, code, attr, pos, phase, mattr, 8'($urandom)};
    return it;
  endfunction

  function automatic cell_item_t font_write(input logic [7:0] code, input logic [7:0] data);
    cell_item_t it;
    it = '{ACT_WRITE, code, 6'($urandom), 2'($urandom), 1'($urandom), 8'($urandom), data};
    return it;
  endfunction

  function automatic cell_item_t random_item();
    cell_item_t it;
    it.action = ($urandom_range(0, 7) == 0) ? ACT_WRITE : ACT_RENDER;
    case ($urandom_range(0, 3))
      0: it.code = {1'($urandom), 7'($urandom_range(7'h41, 7'h5A))};
      1: it.code = {1'($urandom), 7'($urandom_range(7'h61, 7'h7A))};
      default: it.code = 8'($urandom);
    endcase
    if ($urandom_range(0, 1)) it.attr = 6'($urandom);
    else it.attr = 6'($urandom_range(0, 1)) << $urandom_range(0, 5);
    it.pos = 2'($urandom);
    it.phase = 1'($urandom);
    it.mattr = 8'($urandom);
    it.fdata = 8'($urandom);
    return it;
  endfunction

  task automatic send_item(input cell_item_t it);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    action <= it.action;
    char_code <= it.code;
    char_attr <= it.attr;
    digit_position <= it.pos;
    blink_phase <= it.phase;
    module_attr <= it.mattr;
    font_data <= it.fdata;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    if (it.action == ACT_WRITE) begin
      if (it.code[6:0] >= 7'd32) glyph_mem[it.code[6:0] - 7'd32] = it.fdata;
    end else begin
      due_renders.push_back(render_result(it));
    end
  endtask

  // font writes give no result, so allow the pipeline to settle after the last one
  task automatic wait_idle();
    push <= 1'b0;
    while (due_renders.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= 8'(idx);
    cfg_data <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      sscr_pkg::CFG_LOWERCASE: lowercase_on = val[0];
      sscr_pkg::CFG_DOT_MODE:  dot_sel = val;
      sscr_pkg::CFG_GLOBAL_BR: bright_scale = val[3:0];
      sscr_pkg::CFG_XOR_MASK:  xor_pattern = val;
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic lc, input logic [7:0] dm, input logic [3:0] gb,
                               input logic [7:0] xm);
    wait_idle();
    write_register(sscr_pkg::CFG_LOWERCASE, 8'(lc));
    write_register(sscr_pkg::CFG_DOT_MODE, dm);
    write_register(sscr_pkg::CFG_GLOBAL_BR, 8'(gb));
    write_register(sscr_pkg::CFG_XOR_MASK, xm);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    mismatch_count++;
    $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
  endtask

  initial begin : result_checker
    sscr_pkg::result_t got;
    sscr_pkg::result_t want;
    int      stall;
    wait (rst === 1'b0);
    forever begin
      stall = recv_idle_on ? $urandom_range(0, 15) : 0;
      stall += recv_hold;
      recv_hold = 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty !== 1'b0) @(posedge clk);
      got.segment_data = segment_data;
      got.digit_register = digit_register;
      got.module_brightness = module_brightness;
      got.module_blink = module_blink;
      got.colon_bits = colon_bits;
      if (due_renders.size() == 0) begin
        report_mismatch("unexpected item, segment_data", 8'h00, got.segment_data);
      end else begin
        want = due_renders.pop_front();
        if (got.segment_data !== want.segment_data)
          report_mismatch("segment_data", want.segment_data, got.segment_data);
        if (got.digit_register !== want.digit_register)
          report_mismatch("digit_register", 8'(want.digit_register), 8'(got.digit_register));
        if (got.module_brightness !== want.module_brightness)
          report_mismatch("module_brightness", 8'(want.module_brightness),
                          8'(got.module_brightness));
        if (got.module_blink !== want.module_blink)
          report_mismatch("module_blink", 8'(want.module_blink), 8'(got.module_blink));
        if (got.colon_bits !== want.colon_bits)
          report_mismatch("colon_bits", 8'(want.colon_bits), 8'(got.colon_bits));
      end
    end
  end

  task automatic test_builtin_glyphs();
    send_item(render_cell(8'h41, 6'h00, 2'd0, 1'b0, 8'h00));
    send_item(render_cell(8'h61, 6'h00, 2'd1, 1'b0, 8'hFF));
    send_item(render_cell(8'h00, 6'h00, 2'd2, 1'b0, 8'hF0));
    send_item(render_cell(8'h1F, 6'h00, 2'd3, 1'b1, 8'h0F));
    send_item(render_cell(8'h20, 6'h00, 2'd0, 1'b0, 8'h5A));
    send_item(render_cell(8'h7F, 6'h00, 2'd1, 1'b0, 8'hA5));
    send_item(render_cell(8'hFF, 6'h00, 2'd2, 1'b0, 8'h70));
    // raw, hidden, blink off and on, invert, dot, all attributes
    send_item(render_cell(8'hA5, 6'h01, 2'd3, 1'b0, 8'h30));
    send_item(render_cell(8'h41, 6'h02, 2'd0, 1'b0, 8'h80));
    send_item(render_cell(8'h41, 6'h04, 2'd1, 1'b1, 8'h10));
    send_item(render_cell(8'h41, 6'h04, 2'd2, 1'b0, 8'h20));
    send_item(render_cell(8'h38, 6'h08, 2'd3, 1'b0, 8'h40));
    send_item(render_cell(8'h38, 6'h20, 2'd0, 1'b0, 8'hE0));
    send_item(render_cell(8'hFF, 6'h3F, 2'd1, 1'b1, 8'hFF));
  endtask

  task automatic test_font_writes();
    send_item(font_write(8'h10, 8'hAA));
    send_item(font_write(8'h9F, 8'h55));
    send_item(font_write(8'hC1, 8'h81));
    send_item(render_cell(8'h41, 6'h00, 2'd2, 1'b0, 8'hF3));
    send_item(render_cell(8'h10, 6'h00, 2'd3, 1'b0, 8'h0C));
    send_item(font_write(8'h7F, 8'hFF));
    send_item(render_cell(8'h7F, 6'h00, 2'd0, 1'b0, 8'h11));
  endtask

  task automatic test_register_extremes();
    set_registers(1'b0, 8'hFF, 4'd0, 8'hFF);
    send_item(render_cell(8'h61, 6'h00, 2'd1, 1'b0, 8'hF0));
    send_item(render_cell(8'hDA, 6'h00, 2'd2, 1'b0, 8'hFF));
    send_item(render_cell(8'hE1, 6'h10, 2'd3, 1'b0, 8'h77));
    set_registers(1'b1, 8'h03, 4'd7, 8'h5A);
    send_item(render_cell(8'h7A, 6'h10, 2'd0, 1'b0, 8'hF0));
    send_item(render_cell(8'h5A, 6'h00, 2'd1, 1'b0, 8'h90));
  endtask

  task automatic test_full_stall();
    set_registers(1'b1, 8'h00, 4'd15, 8'h00);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    recv_hold = 80;
    repeat (30) begin
      send_item(render_cell(8'($urandom), 6'($urandom), 2'($urandom), 1'($urandom),
                            8'($urandom)));
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_registers(1'b0, 8'h00, 4'd0, 8'h00);
        1: set_registers(1'b1, 8'hFF, 4'd15, 8'hFF);
        default: set_registers(1'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
      endcase
      send_idle_on = (p != 1) && $urandom_range(0, 3) != 0;
      recv_idle_on = (p != 1) && $urandom_range(0, 3) != 0;
      repeat (65) send_item(random_item());
    end
  endtask

  initial begin
    for (int i = 0; i < 96; i++) glyph_mem[i] = GLYPH_INIT[i];
    lowercase_on = 1'b1;
    dot_sel = 8'h00;
    bright_scale = 4'd15;
    xor_pattern = 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_builtin_glyphs();
    test_font_writes();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    test_register_extremes();
    test_full_stall();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
